>>> design/hrsl_pkg.sv
// Package for the HTTP request span lexer: character codes, span kind codes
// and the result record passed from the lexer core to the top level.
// No dependencies.
`default_nettype none

package hrsl_pkg;

  // Delimiter characters
  localparam logic [7:0] CHAR_SP = 8'h20;
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_CR = 8'h0D;

  // Fixed widths of the result fields
  localparam int unsigned POS_W  = 12;
  localparam int unsigned HIDX_W = 6;

  // Span kind reported on the closing byte
  typedef enum logic [2:0] {
    KIND_NONE    = 3'd0,
    KIND_METHOD  = 3'd1,
    KIND_URI     = 3'd2,
    KIND_VERSION = 3'd3,
    KIND_KEY     = 3'd4,
    KIND_VALUE   = 3'd5
  } token_kind_t;

  // One result item
  typedef struct packed {
    token_kind_t         kind;
    logic [POS_W-1:0]    start;
    logic [POS_W-1:0]    length;
    logic [HIDX_W-1:0]   hidx;
    logic                done;
    logic                body;
    logic                ovf;
  } lex_result_t;

endpackage

`default_nettype wire

>>> design/hrsl_lexer.sv
// Lexer core: parse state registers and the per-byte next-state and result
// logic. Depends on hrsl_pkg.
`default_nettype none

module hrsl_lexer #(
  parameter int unsigned MAX_REQUEST_BYTES = 4096,
  parameter int unsigned MAX_HEADERS       = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                step,
  input  wire logic [7:0]          data_byte,
  input  wire logic                new_request,
  output hrsl_pkg::lex_result_t    result
);
  import hrsl_pkg::*;

  localparam int unsigned OW = $clog2(MAX_REQUEST_BYTES);
  localparam int unsigned HW = $clog2(MAX_HEADERS + 1);
  localparam logic [OW-1:0] OFF_LAST = OW'(MAX_REQUEST_BYTES - 1);
  localparam logic [HW-1:0] HDR_MAX  = HW'(MAX_HEADERS);

  typedef enum logic [2:0] {
    PH_BEGIN   = 3'd0,
    PH_METHOD  = 3'd1,
    PH_URI     = 3'd2,
    PH_VERSION = 3'd3,
    PH_KEY     = 3'd4,
    PH_VALUE   = 3'd5,
    PH_LINE    = 3'd6,
    PH_BODY    = 3'd7
  } phase_t;

  phase_t        phase, phase_next, cur_phase;
  logic [OW-1:0] byte_offset, byte_offset_next, cur_offset;
  logic [OW-1:0] span_start, span_start_next, cur_start;
  logic          span_started, span_started_next, cur_started;
  logic [HW-1:0] header_count, header_count_next, cur_count;
  logic          overflow_flag, overflow_flag_next, cur_ovf;

  // Span length from start to end less drop bytes, floored at zero
  function automatic logic [POS_W-1:0] span_len(input logic [OW-1:0] end_pos,
                                               input logic [OW-1:0] start_pos,
                                               input logic          drop);
    logic [OW:0]         lim;
    logic [OW:0]         diff;
    logic [OW+POS_W-1:0] wide;
    lim  = {1'b0, start_pos} + {{OW{1'b0}}, drop};
    diff = {1'b0, end_pos} - lim;
    wide = {{POS_W{1'b0}}, diff[OW-1:0]};
    if ({1'b0, end_pos} < lim) begin
      span_len = '0;
    end else begin
      span_len = wide[POS_W-1:0];
    end
  endfunction

  // Offset narrowed or widened to the result field
  function automatic logic [POS_W-1:0] to_pos(input logic [OW-1:0] v);
    logic [OW+POS_W-1:0] wide;
    wide   = {{POS_W{1'b0}}, v};
    to_pos = wide[POS_W-1:0];
  endfunction

  function automatic logic [HIDX_W-1:0] to_hidx(input logic [HW-1:0] v);
    logic [HW+HIDX_W-1:0] wide;
    wide    = {{HIDX_W{1'b0}}, v};
    to_hidx = wide[HIDX_W-1:0];
  endfunction

  // Start of a new request clears the state seen by this byte
  always_comb begin
    cur_phase   = new_request ? PH_BEGIN : phase;
    cur_offset  = new_request ? '0 : byte_offset;
    cur_start   = new_request ? '0 : span_start;
    cur_started = new_request ? 1'b0 : span_started;
    cur_count   = new_request ? '0 : header_count;
    cur_ovf     = new_request ? 1'b0 : overflow_flag;
  end

  // Phase transitions and span reporting
  always_comb begin
    phase_next         = cur_phase;
    span_start_next    = cur_start;
    span_started_next  = cur_started;
    header_count_next  = cur_count;
    overflow_flag_next = cur_ovf;
    byte_offset_next   = cur_offset;
    result             = '0;

    case (cur_phase)
      PH_BEGIN: begin
        span_start_next   = cur_offset;
        span_started_next = 1'b1;
        phase_next        = PH_METHOD;
      end
      PH_METHOD: begin
        if (data_byte == CHAR_SP) begin
          result.kind       = KIND_METHOD;
          result.start      = to_pos(cur_start);
          result.length     = span_len(cur_offset, cur_start, 1'b0);
          span_started_next = 1'b0;
          phase_next        = PH_URI;
        end
      end
      PH_URI: begin
        if (!cur_started) begin
          span_start_next   = cur_offset;
          span_started_next = 1'b1;
        end else if (data_byte == CHAR_SP) begin
          result.kind       = KIND_URI;
          result.start      = to_pos(cur_start);
          result.length     = span_len(cur_offset, cur_start, 1'b0);
          span_started_next = 1'b0;
          phase_next        = PH_VERSION;
        end
      end
      PH_VERSION: begin
        if (!cur_started) begin
          span_start_next   = cur_offset;
          span_started_next = 1'b1;
        end else if (data_byte == CHAR_LF) begin
          result.kind       = KIND_VERSION;
          result.start      = to_pos(cur_start);
          result.length     = span_len(cur_offset, cur_start, 1'b1);
          span_started_next = 1'b0;
          phase_next        = PH_KEY;
        end
      end
      PH_KEY: begin
        if (!cur_started) begin
          span_start_next   = cur_offset;
          span_started_next = 1'b1;
        end else if (data_byte == CHAR_SP) begin
          result.kind       = KIND_KEY;
          result.start      = to_pos(cur_start);
          result.length     = span_len(cur_offset, cur_start, 1'b1);
          result.hidx       = to_hidx(cur_count);
          span_started_next = 1'b0;
          phase_next        = PH_VALUE;
        end
      end
      PH_VALUE: begin
        if (!cur_started) begin
          span_start_next   = cur_offset;
          span_started_next = 1'b1;
        end else if (data_byte == CHAR_LF) begin
          result.kind   = KIND_VALUE;
          result.start  = to_pos(cur_start);
          result.length = span_len(cur_offset, cur_start, 1'b1);
          result.hidx   = to_hidx(cur_count);
          // header count saturates at the limit
          if (cur_count < HDR_MAX) begin
            header_count_next = cur_count + 1'b1;
          end else begin
            overflow_flag_next = 1'b1;
          end
          span_started_next = 1'b0;
          phase_next        = PH_LINE;
        end
      end
      PH_LINE: begin
        if (data_byte == CHAR_LF) begin
          result.done = 1'b1;
          phase_next  = PH_BODY;
        end else if (data_byte != CHAR_CR) begin
          span_start_next   = cur_offset;
          span_started_next = 1'b1;
          phase_next        = PH_KEY;
        end
      end
      default: begin
        result.body = 1'b1;
      end
    endcase

    // offset saturates on the last position
    if (cur_offset < OFF_LAST) begin
      byte_offset_next = cur_offset + 1'b1;
    end else begin
      overflow_flag_next = 1'b1;
    end

    result.ovf = overflow_flag_next;
  end

  // State registers, updated once per transfer into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_BEGIN;
      byte_offset   <= '0;
      span_start    <= '0;
      span_started  <= 1'b0;
      header_count  <= '0;
      overflow_flag <= 1'b0;
    end else if (step) begin
      phase         <= phase_next;
      byte_offset   <= byte_offset_next;
      span_start    <= span_start_next;
      span_started  <= span_started_next;
      header_count  <= header_count_next;
      overflow_flag <= overflow_flag_next;
    end
  end

endmodule

`default_nettype wire

>>> design/http_request_span_lexer.sv
// Top level of the HTTP request span lexer: input register, lexer core and
// result register with valid/stall handshakes. Depends on hrsl_pkg, hrsl_lexer.
//
//  channel | direction | handshake           | payload
//  in      | input     | in_valid / in_stall | data_byte, new_request
//  out     | output    | out_valid/out_stall | token_kind, token_start, token_length,
//          |           |                     | header_index, headers_done, in_body, overflow
//
// One byte per cycle sustained while out_stall is low; each byte passes the input
// register, then the parse logic into the result register.
// Synchronous active-high rst clears the parse state and both valid flags.
// A stalled result holds the result register; the input register takes one
// more byte if it was empty, then in_stall rises until the result is taken.
`default_nettype none

module http_request_span_lexer #(
  parameter int unsigned MAX_REQUEST_BYTES = 4096,
  parameter int unsigned MAX_HEADERS       = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        new_request,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       token_kind,
  output logic [11:0]      token_start,
  output logic [11:0]      token_length,
  output logic [5:0]       header_index,
  output logic             headers_done,
  output logic             in_body,
  output logic             overflow
);
  import hrsl_pkg::*;

  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_new;
  logic        load_out;
  logic        advance;
  lex_result_t lex_res;
  lex_result_t res_reg;

  // Pipeline flow control
  assign load_out = !out_valid || !out_stall;
  assign advance  = s1_valid && load_out;
  assign in_stall = s1_valid && !load_out;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte <= data_byte;
      s1_new  <= new_request;
    end
  end

  hrsl_lexer #(
    .MAX_REQUEST_BYTES (MAX_REQUEST_BYTES),
    .MAX_HEADERS       (MAX_HEADERS)
  ) u_lexer (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .data_byte   (s1_byte),
    .new_request (s1_new),
    .result      (lex_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_reg <= lex_res;
    end
  end

  assign token_kind   = res_reg.kind;
  assign token_start  = res_reg.start;
  assign token_length = res_reg.length;
  assign header_index = res_reg.hidx;
  assign headers_done = res_reg.done;
  assign in_body      = res_reg.body;
  assign overflow     = res_reg.ovf;

endmodule

`default_nettype wire
